// ===== rtl/core/bis_pkg.sv =====
// Shared constants and register codes of the bilinear RGB scaler.
`default_nettype none
package bis_pkg;
    localparam int MAX_SRC_WIDTH_DEF  = 1024;
    localparam int MAX_SRC_HEIGHT_DEF = 1024;
    localparam int MAX_DST_SIDE_DEF   = 1024;

    localparam int COORD_W = 10;
    localparam int CFG_W   = 11;
    localparam int PIX_W   = 8;
    localparam int RGB_W   = 3 * PIX_W;

    localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;
    localparam logic [PIX_W-1:0] PIX_MAX    = 8'd255;

    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } reg_index_t;

    typedef enum logic {
        FUNC_WRITE   = 1'b0,
        FUNC_REQUEST = 1'b1
    } func_t;
endpackage
`default_nettype wire

// ===== rtl/core/bis_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bis_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/bis_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none
module bis_div #(
    parameter int NW = 34,
    parameter int DVW = 25
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [NW-1:0]  dividend,
    input  wire logic [DVW-1:0] divisor,
    output logic                busy,
    output logic                done,
    output logic [NW-1:0]       quot,
    output logic [DVW-1:0]      rem
);
    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0]  cnt_reg;
    logic           act_reg;
    logic           done_reg;
    logic [DVW-1:0] rem_reg;
    logic [NW-1:0]  quo_reg;
    logic [DVW-1:0] dsr_reg;
    logic [DVW:0]   part;
    logic [DVW+1:0] diff;
    logic           ge;

    assign part = {rem_reg, quo_reg[NW-1]};
    assign diff = {1'b0, part} - {2'b00, dsr_reg};
    assign ge   = !diff[DVW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            act_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !act_reg)
            begin
                act_reg <= 1'b1;
                cnt_reg <= CW'(NW);
                rem_reg <= '0;
                quo_reg <= dividend;
                dsr_reg <= divisor;
            end
            else if (act_reg)
            begin
                rem_reg <= ge ? diff[DVW-1:0] : part[DVW-1:0];
                quo_reg <= {quo_reg[NW-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    act_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = act_reg;
    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;
endmodule
`default_nettype wire

// ===== rtl/core/bilinear_rgb_image_scaler.sv =====
// Bilinear RGB888 scaler with half-pixel centres over a source frame memory.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------------------
//  input    | start, busy                 | func, coord_x, coord_y, pixel_red/green/blue
//  result   | done (one-cycle strobe)     | result_red/green/blue, coord_error
//  config   | cfg_valid, cfg_ready        | cfg_index, cfg_data
//
// A pixel write leaves busy low. A request runs a sequencer that keeps busy high:
// two axis mappings and three channel roundings each use the shared divider, besides
// setup, four frame reads and the multiplies.
// An out-of-range request answers in the next cycle with coord_error.
// Reset idles the sequencer and sets all sizes to 1024; frame contents undefined until written.
// The receiver cannot stall: done is high for exactly one cycle per request.
`default_nettype none
module bilinear_rgb_image_scaler #(
    parameter int MAX_SRC_WIDTH  = bis_pkg::MAX_SRC_WIDTH_DEF,
    parameter int MAX_SRC_HEIGHT = bis_pkg::MAX_SRC_HEIGHT_DEF,
    parameter int MAX_DST_SIDE   = bis_pkg::MAX_DST_SIDE_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          func,
    input  wire logic [bis_pkg::COORD_W-1:0]   coord_x,
    input  wire logic [bis_pkg::COORD_W-1:0]   coord_y,
    input  wire logic [bis_pkg::PIX_W-1:0]     pixel_red,
    input  wire logic [bis_pkg::PIX_W-1:0]     pixel_green,
    input  wire logic [bis_pkg::PIX_W-1:0]     pixel_blue,
    output logic                               done,
    output logic [bis_pkg::PIX_W-1:0]          result_red,
    output logic [bis_pkg::PIX_W-1:0]          result_green,
    output logic [bis_pkg::PIX_W-1:0]          result_blue,
    output logic                               coord_error,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [bis_pkg::CFG_W-1:0]     cfg_data
);
    import bis_pkg::*;

    localparam int SXW  = $clog2(MAX_SRC_WIDTH + 1);
    localparam int SYW  = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int SMW  = (SXW > SYW) ? SXW : SYW;
    localparam int DSW  = $clog2(MAX_DST_SIDE + 1);
    localparam int DXW  = $clog2(2 * MAX_DST_SIDE + 1);
    localparam int DENW = 2 * DXW;
    localparam int TW   = DXW + PIX_W;
    localparam int NMW  = DENW + PIX_W;
    localparam int PW   = COORD_W + 1 + SMW;
    localparam int NW   = (NMW + 2 > PW) ? NMW + 2 : PW;
    localparam int DVW  = DENW + 1;
    localparam int XIW  = $clog2(MAX_SRC_WIDTH);
    localparam int YIW  = $clog2(MAX_SRC_HEIGHT);
    localparam int AW   = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);
    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;

    typedef enum logic [4:0] {
        S_IDLE, S_XP, S_XN, S_XW, S_YP, S_YN, S_YW,
        S_R0, S_R1, S_R2, S_R3, S_R4,
        S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_CD, S_CW
    } state_t;

    state_t state_reg;

    logic [CFG_W-1:0] sw_cfg_reg, sh_cfg_reg, dw_cfg_reg, dh_cfg_reg;
    logic [SXW-1:0]   sw;
    logic [SYW-1:0]   sh;
    logic [DSW-1:0]   dw, dh;
    logic [DXW-1:0]   dx, dy;

    logic [COORD_W-1:0] x_reg, y_reg;
    logic [PW-1:0]      pos_reg;
    logic [XIW-1:0]     x0_reg, x1_reg;
    logic [YIW-1:0]     y0_reg, y1_reg;
    logic [DXW-1:0]     rx_reg, ry_reg;
    logic [DENW-1:0]    den_reg;
    logic [RGB_W-1:0]   p_reg [4];
    logic [1:0]         ch_reg;
    logic [TW-1:0]      acc_reg, top_reg, bot_reg;
    logic [NMW-1:0]     prod_reg;
    logic [PIX_W-1:0]   res_reg [3];
    logic               done_reg, err_reg;

    logic           accept, in_range, wr_ok;
    logic           div_start, div_busy, div_done;
    logic [NW-1:0]  div_num, div_q;
    logic [DVW-1:0] div_den, div_r;
    logic [AW-1:0]  waddr, raddr;
    logic [RGB_W-1:0] rdata;
    logic [PW-1:0]  pos_sub;
    logic [XIW-1:0] qx;
    logic [YIW-1:0] qy;
    logic [PIX_W-1:0] b0, b1, b2, b3;

    function automatic logic [PIX_W-1:0] pick(input logic [RGB_W-1:0] p, input logic [1:0] c);
        logic [PIX_W-1:0] r;
        case (c)
            2'd0:    r = p[23:16];
            2'd1:    r = p[15:8];
            default: r = p[7:0];
        endcase
        return r;
    endfunction

    always_comb
    begin
        if (sw_cfg_reg == '0) sw = SXW'(1);
        else if (32'(sw_cfg_reg) > 32'(MAX_SRC_WIDTH)) sw = SXW'(MAX_SRC_WIDTH);
        else sw = SXW'(sw_cfg_reg);
        if (sh_cfg_reg == '0) sh = SYW'(1);
        else if (32'(sh_cfg_reg) > 32'(MAX_SRC_HEIGHT)) sh = SYW'(MAX_SRC_HEIGHT);
        else sh = SYW'(sh_cfg_reg);
        if (dw_cfg_reg == '0) dw = DSW'(1);
        else if (32'(dw_cfg_reg) > 32'(MAX_DST_SIDE)) dw = DSW'(MAX_DST_SIDE);
        else dw = DSW'(dw_cfg_reg);
        if (dh_cfg_reg == '0) dh = DSW'(1);
        else if (32'(dh_cfg_reg) > 32'(MAX_DST_SIDE)) dh = DSW'(MAX_DST_SIDE);
        else dh = DSW'(dh_cfg_reg);
    end

    assign dx = DXW'({dw, 1'b0});
    assign dy = DXW'({dh, 1'b0});

    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign in_range  = (32'(coord_x) < 32'(dw)) && (32'(coord_y) < 32'(dh));
    assign wr_ok     = accept && (func == FUNC_WRITE)
                       && (32'(coord_x) < 32'(sw)) && (32'(coord_y) < 32'(sh));
    assign waddr     = AW'(32'(coord_y) * MAX_SRC_WIDTH + 32'(coord_x));

    always_comb
    begin
        unique case (state_reg)
            S_R1:    raddr = AW'(32'(y0_reg) * MAX_SRC_WIDTH + 32'(x1_reg));
            S_R2:    raddr = AW'(32'(y1_reg) * MAX_SRC_WIDTH + 32'(x0_reg));
            S_R3:    raddr = AW'(32'(y1_reg) * MAX_SRC_WIDTH + 32'(x1_reg));
            default: raddr = AW'(32'(y0_reg) * MAX_SRC_WIDTH + 32'(x0_reg));
        endcase
    end

    bis_ram #(.WIDTH(RGB_W), .DEPTH(DEPTH)) u_frame (
        .clk   (clk),
        .we    (wr_ok),
        .waddr (waddr),
        .wdata ({pixel_red, pixel_green, pixel_blue}),
        .raddr (raddr),
        .rdata (rdata)
    );

    // (2d+1)*src - dst, clamped at zero
    assign pos_sub = (state_reg == S_XN)
        ? ((pos_reg > PW'(dw)) ? pos_reg - PW'(dw) : '0)
        : ((pos_reg > PW'(dh)) ? pos_reg - PW'(dh) : '0);

    always_comb
    begin
        div_start = 1'b0;
        div_num   = NW'({prod_reg, 1'b0}) + NW'(den_reg);
        div_den   = DVW'({den_reg, 1'b0});
        case (state_reg)
            S_XN:
            begin
                div_start = 1'b1;
                div_num   = NW'(pos_sub);
                div_den   = DVW'(dx);
            end
            S_YN:
            begin
                div_start = 1'b1;
                div_num   = NW'(pos_sub);
                div_den   = DVW'(dy);
            end
            S_CD:    div_start = 1'b1;
            default: div_start = 1'b0;
        endcase
    end

    bis_div #(.NW(NW), .DVW(DVW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    assign qx = XIW'(div_q);
    assign qy = YIW'(div_q);
    assign b0 = pick(p_reg[0], ch_reg);
    assign b1 = pick(p_reg[1], ch_reg);
    assign b2 = pick(p_reg[2], ch_reg);
    assign b3 = pick(p_reg[3], ch_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            err_reg    <= 1'b0;
            ch_reg     <= '0;
            sw_cfg_reg <= SIZE_RESET;
            sh_cfg_reg <= SIZE_RESET;
            dw_cfg_reg <= SIZE_RESET;
            dh_cfg_reg <= SIZE_RESET;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (reg_index_t'(cfg_index))
                    REG_SRC_WIDTH:  sw_cfg_reg <= cfg_data;
                    REG_SRC_HEIGHT: sh_cfg_reg <= cfg_data;
                    REG_DST_WIDTH:  dw_cfg_reg <= cfg_data;
                    REG_DST_HEIGHT: dh_cfg_reg <= cfg_data;
                    default:        sw_cfg_reg <= sw_cfg_reg;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && (func == FUNC_REQUEST))
                    begin
                        x_reg <= coord_x;
                        y_reg <= coord_y;
                        if (in_range)
                        begin
                            state_reg <= S_XP;
                        end
                        else
                        begin
                            done_reg   <= 1'b1;
                            err_reg    <= 1'b1;
                            res_reg[0] <= '0;
                            res_reg[1] <= '0;
                            res_reg[2] <= '0;
                        end
                    end
                end
                S_XP:
                begin
                    pos_reg   <= PW'({x_reg, 1'b1}) * PW'(sw);
                    state_reg <= S_XN;
                end
                S_XN: state_reg <= S_XW;
                S_XW:
                begin
                    if (div_done)
                    begin
                        x0_reg    <= qx;
                        rx_reg    <= DXW'(div_r);
                        x1_reg    <= (SXW'(qx) + SXW'(1) < sw) ? qx + 1'b1 : qx;
                        state_reg <= S_YP;
                    end
                end
                S_YP:
                begin
                    pos_reg   <= PW'({y_reg, 1'b1}) * PW'(sh);
                    state_reg <= S_YN;
                end
                S_YN: state_reg <= S_YW;
                S_YW:
                begin
                    if (div_done)
                    begin
                        y0_reg    <= qy;
                        ry_reg    <= DXW'(div_r);
                        y1_reg    <= (SYW'(qy) + SYW'(1) < sh) ? qy + 1'b1 : qy;
                        state_reg <= S_R0;
                    end
                end
                S_R0:
                begin
                    den_reg   <= DENW'(dx) * DENW'(dy);
                    state_reg <= S_R1;
                end
                S_R1:
                begin
                    p_reg[0]  <= rdata;
                    state_reg <= S_R2;
                end
                S_R2:
                begin
                    p_reg[1]  <= rdata;
                    state_reg <= S_R3;
                end
                S_R3:
                begin
                    p_reg[2]  <= rdata;
                    state_reg <= S_R4;
                end
                S_R4:
                begin
                    p_reg[3]  <= rdata;
                    ch_reg    <= '0;
                    state_reg <= S_C1;
                end
                S_C1:
                begin
                    acc_reg   <= TW'(dx - rx_reg) * TW'(b0);
                    state_reg <= S_C2;
                end
                S_C2:
                begin
                    top_reg   <= acc_reg + TW'(rx_reg) * TW'(b1);
                    state_reg <= S_C3;
                end
                S_C3:
                begin
                    acc_reg   <= TW'(dx - rx_reg) * TW'(b2);
                    state_reg <= S_C4;
                end
                S_C4:
                begin
                    bot_reg   <= acc_reg + TW'(rx_reg) * TW'(b3);
                    state_reg <= S_C5;
                end
                S_C5:
                begin
                    prod_reg  <= NMW'(dy - ry_reg) * NMW'(top_reg);
                    state_reg <= S_C6;
                end
                S_C6:
                begin
                    prod_reg  <= prod_reg + NMW'(ry_reg) * NMW'(bot_reg);
                    state_reg <= S_CD;
                end
                S_CD: state_reg <= S_CW;
                S_CW:
                begin
                    if (div_done)
                    begin
                        res_reg[ch_reg] <= (div_q > NW'(PIX_MAX)) ? PIX_MAX : PIX_W'(div_q);
                        if (ch_reg == 2'd2)
                        begin
                            done_reg  <= 1'b1;
                            err_reg   <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= S_C1;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign coord_error  = err_reg;
    assign result_red   = res_reg[0];
    assign result_green = res_reg[1];
    assign result_blue  = res_reg[2];

`ifndef NO_ASSERTIONS
    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && coord_error) |-> (result_red == '0 && result_green == '0 && result_blue == '0))
        else $error("error result carries data");
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || (start && func == FUNC_REQUEST)))
        else $error("result strobe without a request");
    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !coord_error) |-> !busy)
        else $error("sequencer still running after result");
`endif
endmodule
`default_nettype wire
